// File: sv/ddo_pkg.sv
package ddo_pkg;

  // Serial multiplier geometry: signed A times signed B, one B bit per cycle
  localparam int MUL_AW = 34;
  localparam int MUL_BW = 32;
  localparam int MUL_PW = MUL_AW + MUL_BW;
  localparam int MUL_CW = $clog2(MUL_BW);

  // Serial divider geometry
  localparam int DIV_NW = 49;
  localparam int SEP_W  = 20;
  localparam int RAD_W  = 16;

  // CORDIC datapath width (Q30 values with headroom)
  localparam int CV_W = 34;

  localparam int CORDIC_STEPS_DEF = 20;
  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_FRAC      = 30;

  localparam logic [RAD_W-1:0]       RADIUS_RESET   = 16'd2163;
  localparam logic [SEP_W-1:0]       SEP_RESET      = 20'd10486;
  localparam logic [MUL_BW-1:0]      INV_TWO_PI_Q32 = 32'd683565276;
  localparam logic signed [CV_W-1:0] CORDIC_GAIN    = 34'sd652032874;

  localparam int CFG_IDX_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS     = 8'd0,
    CFG_SEPARATION = 8'd1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_LIN,
    ST_MUL_P,
    ST_DIV,
    ST_MUL_BAM,
    ST_CORDIC,
    ST_MUL_X,
    ST_MUL_Y,
    ST_DONE
  } state_t;

  // Arithmetic right shift, round to nearest with ties up
  function automatic logic signed [MUL_PW-1:0] rnd_shr(input logic signed [MUL_PW-1:0] v,
                                                       input int unsigned s);
    logic signed [MUL_PW-1:0] one;
    one = 66'sd1;
    return (v + (one <<< (s - 1))) >>> s;
  endfunction

  // Clamp to the 32-bit signed range
  function automatic logic signed [31:0] sat32(input logic signed [MUL_PW-1:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -66'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  // Arctangent of 2^-i as a binary angle, full turn 2^32
  function automatic logic [29:0] atan_bam(input logic [4:0] idx);
    case (idx)
      5'd0:  return 30'd536870912;
      5'd1:  return 30'd316933406;
      5'd2:  return 30'd167458907;
      5'd3:  return 30'd85004756;
      5'd4:  return 30'd42667331;
      5'd5:  return 30'd21354465;
      5'd6:  return 30'd10679838;
      5'd7:  return 30'd5340245;
      5'd8:  return 30'd2670163;
      5'd9:  return 30'd1335087;
      5'd10: return 30'd667544;
      5'd11: return 30'd333772;
      5'd12: return 30'd166886;
      5'd13: return 30'd83443;
      5'd14: return 30'd41722;
      5'd15: return 30'd20861;
      5'd16: return 30'd10430;
      5'd17: return 30'd5215;
      5'd18: return 30'd2608;
      5'd19: return 30'd1304;
      5'd20: return 30'd652;
      5'd21: return 30'd326;
      5'd22: return 30'd163;
      5'd23: return 30'd81;
      5'd24: return 30'd41;
      5'd25: return 30'd20;
      5'd26: return 30'd10;
      5'd27: return 30'd5;
      5'd28: return 30'd3;
      5'd29: return 30'd1;
      default: return 30'd0;
    endcase
  endfunction

endpackage

// File: sv/ddo_mul.sv
module ddo_mul
  import ddo_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [MUL_AW-1:0] a,
  input  logic [MUL_BW-1:0]        b,
  output logic                     done,
  output logic signed [MUL_PW-1:0] prod
);

  logic                     busy;
  logic [MUL_CW-1:0]        cnt;
  logic signed [MUL_PW-1:0] acc;
  logic signed [MUL_PW-1:0] a_sh;
  logic [MUL_BW-1:0]        b_sh;
  logic                     last;

  assign last = (cnt == MUL_CW'(MUL_BW - 1));
  assign prod = acc;

  // Shift-add, one multiplier bit per cycle; the sign bit subtracts
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        acc  <= '0;
        a_sh <= {{(MUL_PW - MUL_AW){a[MUL_AW-1]}}, a};
        b_sh <= b;
      end else if (busy) begin
        if (b_sh[0]) begin
          acc <= acc + (last ? -a_sh : a_sh);
        end
        a_sh <= a_sh <<< 1;
        b_sh <= b_sh >> 1;
        cnt  <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: sv/ddo_div.sv
module ddo_div
  import ddo_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_NW-1:0] dividend,
  input  logic [SEP_W-1:0]  divisor,
  output logic              done,
  output logic [DIV_NW-1:0] quotient
);

  localparam int CW = $clog2(DIV_NW);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [SEP_W-1:0]  rem;
  logic [DIV_NW-1:0] n_sh;
  logic [SEP_W:0]    trial;
  logic              fits;

  assign trial = {rem, n_sh[DIV_NW-1]};
  assign fits  = (trial >= {1'b0, divisor});

  // Restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        rem      <= '0;
        n_sh     <= dividend;
        quotient <= '0;
      end else if (busy) begin
        rem      <= fits ? SEP_W'(trial - {1'b0, divisor}) : trial[SEP_W-1:0];
        n_sh     <= n_sh << 1;
        quotient <= {quotient[DIV_NW-2:0], fits};
        cnt      <= cnt + 1'b1;
        if (cnt == CW'(DIV_NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: sv/ddo_cordic.sv
module ddo_cordic
  import ddo_pkg::*;
#(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [31:0]            angle,
  output logic                   done,
  output logic signed [CV_W-1:0] cos_out,
  output logic signed [CV_W-1:0] sin_out
);

  localparam int IW = $clog2(STEPS);

  logic                   busy;
  logic [IW-1:0]          it;
  logic                   flip;
  logic                   flip_in;
  logic signed [CV_W-1:0] x;
  logic signed [CV_W-1:0] y;
  logic signed [32:0]     z;
  logic signed [CV_W-1:0] xs;
  logic signed [CV_W-1:0] ys;
  logic signed [32:0]     at;
  logic [31:0]            a_in;

  assign flip_in = angle[31] ^ angle[30];
  assign a_in    = flip_in ? (angle ^ 32'h80000000) : angle;
  assign xs      = x >>> it;
  assign ys      = y >>> it;
  assign at      = $signed({3'b000, atan_bam(5'(it))});

  // Undo the half-turn fold on the way out
  assign cos_out = flip ? -x : x;
  assign sin_out = flip ? -y : y;

  // One micro-rotation per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        it   <= '0;
        flip <= flip_in;
        x    <= CORDIC_GAIN;
        y    <= '0;
        z    <= {a_in[31], a_in};
      end else if (busy) begin
        if (!z[32]) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - at;
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + at;
        end
        it <= it + 1'b1;
        if (it == IW'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: sv/diff_drive_odometry_top.sv
// Differential-drive wheel odometry, midpoint rule.
// Input stream s_*: one beat per sample of both wheel angles (Q15.16 rad) with a
// valid flag per wheel in s_tuser. Output stream m_*: one beat per input beat
// with pose x/y (saturating Q15.16 m), heading (binary angle, 2^32 per turn) and
// the linear and angular step of that sample.
// Config channel cfg_*: index 0 wheel radius, 1 wheel separation; other
// indexes are dropped. Write only while no sample is in flight.
// Sequence: the first sample after reset only stores angles, and its result
// goes from ST_DONE straight into the output register. A later sample runs
// five bit-serial multiplies, a restoring divide and CORDIC one after the other
// on serial units, all multiplies on the one shared multiplier, and then goes
// through ST_DONE into the output register. The next sample is taken only once
// the block is back in ST_IDLE.
// The result sits in an output register, so a new sample is taken while the
// previous result waits; a stalled receiver holds the block only when the next
// result is done and the register is still full.
// Reset clears pose, heading, stored angles and restores default config.
module diff_drive_odometry_top
  import ddo_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [63:0]          s_tdata,   // left_position, right_position
  input  logic [1:0]           s_tuser,   // left_valid, right_valid
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [159:0]         m_tdata,   // pose_x_out, pose_y_out, heading_out,
                                          // linear_step, angular_step
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  state_t state, state_next;
  logic   started;
  logic   have_prev;

  logic [RAD_W-1:0] radius;
  logic [SEP_W-1:0] separation;
  logic [SEP_W-1:0] sep_eff;

  logic signed [31:0] prev_l, prev_r, dl, dr;
  logic signed [31:0] pose_x, pose_y, lin, ang;
  logic [31:0]        heading, mid;
  logic               p_neg;
  logic [DIV_NW-1:0]  dividend;

  logic                     mul_start, mul_done;
  logic signed [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0]        mul_b;
  logic signed [MUL_PW-1:0] mul_prod, mag;

  logic                     div_start, div_done;
  logic [DIV_NW-1:0]        quot;
  logic signed [MUL_PW-1:0] q_ext;

  logic                   cor_start, cor_done;
  logic signed [CV_W-1:0] cor_cos, cor_sin;

  logic accept, out_free;

  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;
  assign sep_eff   = (separation == '0) ? SEP_W'(1) : separation;
  assign mag       = mul_prod[MUL_PW-1] ? -mul_prod : mul_prod;
  assign q_ext     = {{(MUL_PW - DIV_NW){1'b0}}, quot};

  ddo_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(mul_prod)
  );

  ddo_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(dividend),
    .divisor(sep_eff), .done(div_done), .quotient(quot)
  );

  ddo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .start(cor_start), .angle(mid),
    .done(cor_done), .cos_out(cor_cos), .sin_out(cor_sin)
  );

  // Sequence the shared units and select multiplier operands
  always_comb begin
    state_next = state;
    s_tready   = (state == ST_IDLE);
    mul_start  = 1'b0;
    div_start  = 1'b0;
    cor_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = have_prev ? ST_MUL_LIN : ST_DONE;
        end
      end
      ST_MUL_LIN: begin
        mul_a     = MUL_AW'(dr) + MUL_AW'(dl);
        mul_b     = {{(MUL_BW - RAD_W){1'b0}}, radius};
        mul_start = !started;
        if (mul_done) state_next = ST_MUL_P;
      end
      ST_MUL_P: begin
        mul_a     = MUL_AW'(dr) - MUL_AW'(dl);
        mul_b     = {{(MUL_BW - RAD_W){1'b0}}, radius};
        mul_start = !started;
        if (mul_done) state_next = ST_DIV;
      end
      ST_DIV: begin
        div_start = !started;
        if (div_done) state_next = ST_MUL_BAM;
      end
      ST_MUL_BAM: begin
        mul_a     = MUL_AW'(ang);
        mul_b     = INV_TWO_PI_Q32;
        mul_start = !started;
        if (mul_done) state_next = ST_CORDIC;
      end
      ST_CORDIC: begin
        cor_start = !started;
        if (cor_done) state_next = ST_MUL_X;
      end
      ST_MUL_X: begin
        mul_a     = cor_cos;
        mul_b     = lin;
        mul_start = !started;
        if (mul_done) state_next = ST_MUL_Y;
      end
      ST_MUL_Y: begin
        mul_a     = cor_sin;
        mul_b     = lin;
        mul_start = !started;
        if (mul_done) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Track whether the unit of the current step has been launched
  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
    end else if (state_next != state) begin
      started <= 1'b0;
    end else if (mul_start || div_start || cor_start) begin
      started <= 1'b1;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      radius     <= RADIUS_RESET;
      separation <= SEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RADIUS:     radius     <= cfg_data[RAD_W-1:0];
        CFG_SEPARATION: separation <= cfg_data[SEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Odometry state and step results
  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
      prev_l    <= '0;
      prev_r    <= '0;
      pose_x    <= '0;
      pose_y    <= '0;
      heading   <= '0;
    end else begin
      if (accept) begin
        have_prev <= 1'b1;
        if (s_tuser[0]) prev_l <= s_tdata[31:0];
        if (s_tuser[1]) prev_r <= s_tdata[63:32];
        dl <= s_tuser[0] ? (s_tdata[31:0] - prev_l) : '0;
        dr <= s_tuser[1] ? (s_tdata[63:32] - prev_r) : '0;
        if (!have_prev) begin
          lin <= '0;
          ang <= '0;
        end
      end
      case (state)
        ST_MUL_LIN: begin
          if (mul_done) lin <= sat32(rnd_shr(mul_prod, FRAC_BITS + 1));
        end
        ST_MUL_P: begin
          if (mul_done) begin
            p_neg    <= mul_prod[MUL_PW-1];
            dividend <= mag[DIV_NW-1:0] + DIV_NW'(sep_eff >> 1);
          end
        end
        ST_DIV: begin
          if (div_done) ang <= sat32(p_neg ? -q_ext : q_ext);
        end
        ST_MUL_BAM: begin
          if (mul_done) begin
            mid     <= heading + 32'(rnd_shr(mul_prod, FRAC_BITS + 1));
            heading <= heading + 32'(rnd_shr(mul_prod, FRAC_BITS));
          end
        end
        ST_MUL_X: begin
          if (mul_done) begin
            pose_x <= sat32({{(MUL_PW - 32){pose_x[31]}}, pose_x}
                            + rnd_shr(mul_prod, CORDIC_FRAC));
          end
        end
        ST_MUL_Y: begin
          if (mul_done) begin
            pose_y <= sat32({{(MUL_PW - 32){pose_y[31]}}, pose_y}
                            + rnd_shr(mul_prod, CORDIC_FRAC));
          end
        end
        default: ;
      endcase
    end
  end

  // Output register: load when the result is done and the slot is free
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
      m_tdata  <= {ang, lin, heading, pose_y, pose_x};
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  a_first_zero : assert property (@(posedge clk) disable iff (rst)
    (accept && !have_prev) |=> (lin == '0 && ang == '0 && state == ST_DONE))
    else $error("first sample must give zero steps");

  a_next_lin : assert property (@(posedge clk) disable iff (rst)
    (accept && have_prev) |=> (state == ST_MUL_LIN))
    else $error("later sample must start the linear multiply");

  a_mul_owner : assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == ST_MUL_LIN || state == ST_MUL_P || state == ST_MUL_BAM ||
                  state == ST_MUL_X || state == ST_MUL_Y))
    else $error("multiplier finished outside a multiply step");

  a_hold_done : assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && !out_free) |=> (state == ST_DONE))
    else $error("finished result dropped while output full");

endmodule

// File: dv/diff_drive_odometry_top_tb.sv
module diff_drive_odometry_top_tb
  import ddo_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEPS = CORDIC_STEPS_DEF;
  localparam int FB    = FRAC_BITS_DEF;
  localparam int SETTLE_CYCLES = 300;

  typedef struct {
    logic signed [31:0] left_pos;
    logic signed [31:0] right_pos;
    logic               left_ok;
    logic               right_ok;
  } wheel_sample_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] hdg;
    logic [31:0] lin;
    logic [31:0] ang;
  } pose_t;

  // Arctangent of 2^-i as a binary angle
  localparam longint ATAN_TURN [30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1};

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [63:0]          s_tdata = '0;   // left_position, right_position
  logic [1:0]           s_tuser = '0;   // left_valid, right_valid
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [159:0]         m_tdata;        // pose_x_out, pose_y_out, heading_out,
                                        // linear_step, angular_step
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  diff_drive_odometry_top dut (.*);

  always #1 clk = ~clk;

  wheel_sample_t samples_to_send[$];
  pose_t         poses_expected[$];
  int            error_count = 0;
  bit            idle_on = 1'b1;
  bit            sample_taken = 1'b0;
  int            send_gap = 0;
  int            stall_left = 0;

  // Odometry state mirrored from the block
  logic [15:0]        radius_q;
  logic [19:0]        separation_q;
  logic signed [31:0] last_left, last_right;
  bit                 primed;
  longint             odo_x, odo_y;
  logic [31:0]        odo_heading;

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (!idle_on || roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(20, 200);
  endfunction

  function automatic longint shr_round(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Rotation-mode CORDIC; returns Q30 cosine and sine of a binary angle
  function automatic void cordic_cos_sin(logic [31:0] a, output longint c, output longint s);
    longint z, x, y, nx;
    bit     flip;
    z = longint'($signed(a));
    flip = 1'b0;
    if (z >= 64'sh40000000 || z < -64'sh40000000) begin
      z = longint'($signed(a + 32'h80000000));
      flip = 1'b1;
    end
    x = longint'(CORDIC_GAIN);
    y = 0;
    for (int i = 0; i < STEPS && i < 30; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - ATAN_TURN[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + ATAN_TURN[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // Advance the pose by one wheel sample
  function automatic pose_t odometry_step(wheel_sample_t w);
    pose_t              p;
    longint             lin, ang, dl, dr, prod, q, bam_d, bam_h, c, s;
    longint unsigned    sep, mag;
    logic signed [31:0] d;
    logic [31:0]        mid;
    lin = 0;
    ang = 0;
    if (!primed) begin
      if (w.left_ok) last_left = w.left_pos;
      if (w.right_ok) last_right = w.right_pos;
      primed = 1'b1;
    end else begin
      dl = 0;
      dr = 0;
      if (w.left_ok) begin
        d = w.left_pos - last_left;
        dl = longint'(d);
        last_left = w.left_pos;
      end
      if (w.right_ok) begin
        d = w.right_pos - last_right;
        dr = longint'(d);
        last_right = w.right_pos;
      end
      lin = clamp32(shr_round(longint'(radius_q) * (dr + dl), FB + 1));
      prod = longint'(radius_q) * (dr - dl);
      sep = (separation_q == 0) ? 1 : longint'(separation_q);
      mag = (prod < 0) ? -prod : prod;
      q = (mag + sep / 2) / sep;
      ang = clamp32(prod < 0 ? -q : q);
      bam_d = shr_round(ang * longint'(INV_TWO_PI_Q32), FB);
      bam_h = shr_round(ang * longint'(INV_TWO_PI_Q32), FB + 1);
      mid = odo_heading + bam_h[31:0];
      cordic_cos_sin(mid, c, s);
      odo_x = clamp32(odo_x + shr_round(lin * c, 30));
      odo_y = clamp32(odo_y + shr_round(lin * s, 30));
      odo_heading = odo_heading + bam_d[31:0];
    end
    p.x = odo_x[31:0];
    p.y = odo_y[31:0];
    p.hdg = odo_heading;
    p.lin = lin[31:0];
    p.ang = ang[31:0];
    return p;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Monitor: mirror config writes, predict accepted samples, check results
  always @(posedge clk) begin
    pose_t want;
    sample_taken = 1'b0;
    if (rst) begin
      radius_q = RADIUS_RESET;
      separation_q = SEP_RESET;
      last_left = '0;
      last_right = '0;
      primed = 1'b0;
      odo_x = 0;
      odo_y = 0;
      odo_heading = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_RADIUS) radius_q = cfg_data[15:0];
        else if (cfg_index == CFG_SEPARATION) separation_q = cfg_data[19:0];
      end
      if (s_tvalid && s_tready) begin
        wheel_sample_t w;
        sample_taken = 1'b1;
        w.left_pos = s_tdata[31:0];
        w.right_pos = s_tdata[63:32];
        w.left_ok = s_tuser[0];
        w.right_ok = s_tuser[1];
        poses_expected.push_back(odometry_step(w));
      end
      if (m_tvalid && m_tready) begin
        if (poses_expected.size() == 0) begin
          report_mismatch("unexpected result beat, pose_x", m_tdata[31:0], 32'h0);
        end else begin
          want = poses_expected.pop_front();
          if (m_tdata[31:0] !== want.x) report_mismatch("pose_x", m_tdata[31:0], want.x);
          if (m_tdata[63:32] !== want.y) report_mismatch("pose_y", m_tdata[63:32], want.y);
          if (m_tdata[95:64] !== want.hdg)
            report_mismatch("heading", m_tdata[95:64], want.hdg);
          if (m_tdata[127:96] !== want.lin)
            report_mismatch("linear_step", m_tdata[127:96], want.lin);
          if (m_tdata[159:128] !== want.ang)
            report_mismatch("angular_step", m_tdata[159:128], want.ang);
        end
      end
    end
  end

  // Driver: present queued samples with random gaps
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !sample_taken) begin
      s_tvalid <= 1'b1;
    end else if (send_gap > 0) begin
      send_gap--;
      s_tvalid <= 1'b0;
    end else if (samples_to_send.size() > 0) begin
      wheel_sample_t w;
      w = samples_to_send.pop_front();
      s_tdata <= {w.right_pos, w.left_pos};
      s_tuser <= {w.right_ok, w.left_ok};
      s_tvalid <= 1'b1;
      send_gap = pick_gap();
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // Receiver: random back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_sample(logic [31:0] l, logic [31:0] r, logic lv, logic rv);
    wheel_sample_t w;
    w.left_pos = l;
    w.right_pos = r;
    w.left_ok = lv;
    w.right_ok = rv;
    samples_to_send.push_back(w);
  endtask

  task automatic drain();
    while (samples_to_send.size() > 0 || s_tvalid || poses_expected.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly smooth wheel motion, with jumps, wraps and invalid samples
  task automatic add_motion(int count, int span);
    logic [31:0] l, r;
    int          roll;
    l = $urandom();
    r = $urandom();
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        l = $urandom();
        r = $urandom();
      end else begin
        l = l + $urandom_range(0, 2 * span) - span;
        r = r + $urandom_range(0, 2 * span) - span;
      end
      add_sample(l, r, $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: first sample with one wheel invalid, then extremes and wraps
    add_sample(32'h7FFFFFFF, 32'h12345678, 1'b0, 1'b1);
    add_sample(32'h00010000, 32'h12355678, 1'b1, 1'b1);
    add_sample(32'h7FFFFFFF, 32'h80000000, 1'b1, 1'b1);
    add_sample(32'h80000000, 32'h7FFFFFFF, 1'b1, 1'b1);
    add_sample(32'hFFFFFFFF, 32'h00000000, 1'b0, 1'b0);
    add_sample(32'h00000000, 32'hFFFFFFFF, 1'b1, 1'b0);
    add_sample(32'h55555555, 32'hAAAAAAAA, 1'b1, 1'b1);
    add_sample(32'hAAAAAAAA, 32'h55555555, 1'b1, 1'b1);
    add_sample(32'hAAAAAAAA, 32'h55555555, 1'b1, 1'b1);
    drain();

    // Extreme geometry: largest radius, zero separation treated as one
    write_reg(CFG_RADIUS, 32'h0000FFFF);
    write_reg(CFG_SEPARATION, 32'h00000000);
    add_sample(32'h00000000, 32'h7FFFFFFF, 1'b1, 1'b1);
    add_sample(32'h80000000, 32'h00000000, 1'b1, 1'b1);
    add_sample(32'h7FFFFFFF, 32'h80000000, 1'b1, 1'b1);
    add_motion(40, 2000);
    drain();

    // Smallest radius, widest track; an out-of-range index must be dropped
    write_reg(CFG_RADIUS, 32'hFFFF0001);
    write_reg(CFG_SEPARATION, 32'hFFFFFFFF);
    write_reg(cfg_reg_t'(8'd2), 32'h00000005);
    write_reg(cfg_reg_t'(8'hFF), 32'hFFFFFFFF);
    add_motion(40, 1 << 20);
    drain();

    // Separation of one with default radius
    write_reg(CFG_RADIUS, RADIUS_RESET);
    write_reg(CFG_SEPARATION, 32'd1);
    add_motion(40, 5000);
    drain();

    // Random geometry phases, one with no idling
    for (int ph = 0; ph < 10; ph++) begin
      idle_on = (ph != 4);
      write_reg(CFG_RADIUS, $urandom_range(1, 65535));
      write_reg(CFG_SEPARATION, $urandom_range(1, 1048575));
      add_motion(110, (ph % 3 == 0) ? 100 : (ph % 3 == 1) ? 20000 : 3000000);
      drain();
    end
    idle_on = 1'b1;

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
